@@ rtl/u8c_pkg.sv @@
// ----------------------------------------------------------------------------
// u8c_pkg
// Types, constants and glyph tables for the UTF-8 Cyrillic to LCD code mapper.
// ----------------------------------------------------------------------------
package u8c_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       start_of_string;
        logic       upper_latin;
    } t_in_item;

    typedef struct packed {
        logic [7:0] lcd_code;
        logic       code_valid;
        logic       end_of_string;
        logic [7:0] chars_sent;
    } t_out_item;

    typedef struct packed {
        logic       charset_mode;
        logic [7:0] char_limit;
    } t_cfg;

    // configuration register indexes
    localparam logic CFG_CHARSET_MODE = 1'b0;
    localparam logic CFG_CHAR_LIMIT   = 1'b1;

    localparam logic [7:0] CHAR_LIMIT_RST = 8'd16;

    // held lead byte codes
    localparam logic [1:0] LEAD_NONE = 2'd0;
    localparam logic [1:0] LEAD_D0   = 2'd1;
    localparam logic [1:0] LEAD_D1   = 2'd2;

    localparam logic [7:0] BYTE_NUL     = 8'h00;
    localparam logic [7:0] BYTE_LEAD_D0 = 8'hD0;
    localparam logic [7:0] BYTE_LEAD_D1 = 8'hD1;
    localparam logic [7:0] CODE_UNKNOWN = 8'h3F;
    localparam logic [7:0] ASCII_LOW_A  = 8'h61;
    localparam logic [7:0] ASCII_LOW_Z  = 8'h7A;
    localparam logic [7:0] CASE_DELTA   = 8'h20;

    // U+0410..U+042F, ROM Cyrillic charset
    localparam logic [7:0] ROM_TAB [32] = '{
        8'h41, 8'hA0, 8'h42, 8'hA1, 8'hE0, 8'h45, 8'hA3, 8'hA4,
        8'hA5, 8'hA5, 8'h4B, 8'hA6, 8'h4D, 8'h48, 8'h4F, 8'hA7,
        8'h50, 8'h43, 8'h54, 8'hA8, 8'hA9, 8'h58, 8'hAA, 8'hAB,
        8'hAC, 8'hAD, 8'hAE, 8'hAF, 8'hB0, 8'hB1, 8'hB2, 8'hB3
    };

    // U+0410..U+042F, Latin lookalikes and custom glyphs 0..7
    localparam logic [7:0] LAT_TAB [32] = '{
        8'h41, 8'h00, 8'h42, 8'h01, 8'h02, 8'h45, 8'h03, 8'h33,
        8'h04, 8'h04, 8'h4B, 8'h05, 8'h4D, 8'h48, 8'h4F, 8'hF7,
        8'h50, 8'h43, 8'h54, 8'h59, 8'h06, 8'h58, 8'hF9, 8'h34,
        8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h62, 8'h3F, 8'h07, 8'h3F
    };

endpackage

@@ rtl/u8c_map.sv @@
// ----------------------------------------------------------------------------
// u8c_map
// Maps a code point offset (code point minus U+0400) to an LCD character code.
// ----------------------------------------------------------------------------
module u8c_map
    import u8c_pkg::*;
(
    input  logic [6:0] i_off,
    input  logic       i_rom,
    output logic [7:0] o_code
);

    logic [6:0] fold_off;
    logic [6:0] tab_off;
    logic [7:0] rom_code;
    logic [7:0] lat_code;

    // lowercase and U+0456/0457 fold onto their uppercase rows
    always_comb begin
        if (i_off >= 7'h30 && i_off <= 7'h4F) begin
            fold_off = i_off - 7'h20;
        end else if (i_off == 7'h56 || i_off == 7'h57) begin
            fold_off = i_off - 7'h50;
        end else begin
            fold_off = i_off;
        end
    end

    assign tab_off  = fold_off - 7'h10;
    assign rom_code = ROM_TAB[tab_off[4:0]];
    assign lat_code = LAT_TAB[tab_off[4:0]];

    always_comb begin
        if (fold_off >= 7'h10 && fold_off <= 7'h2F) begin
            o_code = i_rom ? rom_code : lat_code;
        end else if (fold_off == 7'h06) begin
            o_code = 8'h49;
        end else if (fold_off == 7'h07) begin
            o_code = i_rom ? 8'hEA : 8'h49;
        end else begin
            o_code = CODE_UNKNOWN;
        end
    end

endmodule

@@ rtl/u8c_step.sv @@
// ----------------------------------------------------------------------------
// u8c_step
// String state (held lead, count, finished flag) and per-byte decision.
// ----------------------------------------------------------------------------
module u8c_step
    import u8c_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output logic      o_has_result,
    output t_out_item o_result
);

    logic [1:0] r_held_lead, n_held_lead;
    logic [7:0] r_char_count, n_char_count;
    logic       r_finished, n_finished;

    logic [1:0] cur_lead;
    logic [7:0] cur_count;
    logic       cur_fin;
    logic [7:0] cnt_inc;
    logic [7:0] raw_code;
    logic [7:0] map_code;
    logic [6:0] cp_off;

    assign cur_lead  = i_item.start_of_string ? LEAD_NONE : r_held_lead;
    assign cur_count = i_item.start_of_string ? 8'd0 : r_char_count;
    assign cur_fin   = i_item.start_of_string ? 1'b0 : r_finished;
    assign cnt_inc   = cur_count + 8'd1;
    assign cp_off    = {cur_lead == LEAD_D1, i_item.in_byte[5:0]};

    u8c_map u_map (
        .i_off  (cp_off),
        .i_rom  (i_cfg.charset_mode),
        .o_code (map_code)
    );

    always_comb begin
        if (i_item.upper_latin && i_item.in_byte >= ASCII_LOW_A
                && i_item.in_byte <= ASCII_LOW_Z) begin
            raw_code = i_item.in_byte - CASE_DELTA;
        end else begin
            raw_code = i_item.in_byte;
        end
    end

    always_comb begin
        n_held_lead  = cur_lead;
        n_char_count = cur_count;
        n_finished   = cur_fin;
        o_has_result = 1'b0;
        o_result     = '{lcd_code: 8'd0, code_valid: 1'b0, end_of_string: 1'b1,
                         chars_sent: cur_count};
        if (cur_fin) begin
            o_has_result = 1'b0;
        end else if (cur_count >= i_cfg.char_limit) begin
            n_held_lead  = LEAD_NONE;
            n_finished   = 1'b1;
            o_has_result = 1'b1;
        end else if (i_item.in_byte == BYTE_NUL) begin
            n_held_lead  = LEAD_NONE;
            n_finished   = 1'b1;
            o_has_result = 1'b1;
            // dangling lead goes out raw
            if (cur_lead != LEAD_NONE) begin
                n_char_count        = cnt_inc;
                o_result.lcd_code   = (cur_lead == LEAD_D0) ? BYTE_LEAD_D0 : BYTE_LEAD_D1;
                o_result.code_valid = 1'b1;
                o_result.chars_sent = cnt_inc;
            end
        end else if (cur_lead == LEAD_NONE && (i_item.in_byte == BYTE_LEAD_D0
                || i_item.in_byte == BYTE_LEAD_D1)) begin
            n_held_lead = (i_item.in_byte == BYTE_LEAD_D0) ? LEAD_D0 : LEAD_D1;
        end else begin
            n_held_lead            = LEAD_NONE;
            n_char_count           = cnt_inc;
            n_finished             = (cnt_inc >= i_cfg.char_limit);
            o_has_result           = 1'b1;
            o_result.lcd_code      = (cur_lead != LEAD_NONE) ? map_code : raw_code;
            o_result.code_valid    = 1'b1;
            o_result.end_of_string = (cnt_inc >= i_cfg.char_limit);
            o_result.chars_sent    = cnt_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_lead  <= LEAD_NONE;
            r_char_count <= 8'd0;
            r_finished   <= 1'b0;
        end else if (i_fire) begin
            r_held_lead  <= n_held_lead;
            r_char_count <= n_char_count;
            r_finished   <= n_finished;
        end
    end

endmodule

@@ rtl/utf8_cyrillic_to_lcd_charmap.sv @@
// ----------------------------------------------------------------------------
// utf8_cyrillic_to_lcd_charmap
// UTF-8 byte stream in, character LCD codes out, Cyrillic mapped.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                  Payload
// in        input      i_in_valid / o_in_ready    i_in  (t_in_item)
// out       output     o_out_valid / i_out_ready  o_out (t_out_item)
// cfg       input      i_cfg_we                   i_cfg_idx, i_cfg_data
//
// Each byte is registered in the input register, is decoded in one pass and
// lands in the output register, from which its beat is offered; one byte per
// cycle while the output beat is not stalled.
// Lead bytes held for the next byte and bytes after end of string produce no output beat.
// Synchronous active-low reset clears string state and valids and sets config to its defaults.
// A stalled output beat holds the input register; a new byte is taken in
// the same cycle that the pending output beat is taken.
// ----------------------------------------------------------------------------
module utf8_cyrillic_to_lcd_charmap
    import u8c_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out,
    input  logic      i_cfg_we,
    input  logic      i_cfg_idx,
    input  logic [7:0] i_cfg_data
);

    t_cfg      r_cfg;
    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;

    logic      out_free;
    logic      fire;
    logic      has_result;
    t_out_item result;

    assign out_free   = !r_out_valid || i_out_ready;
    assign fire       = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.charset_mode <= 1'b0;
            r_cfg.char_limit   <= CHAR_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CHARSET_MODE: r_cfg.charset_mode <= i_cfg_data[0];
                CFG_CHAR_LIMIT:   r_cfg.char_limit   <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in;
        end
    end

    u8c_step u_step (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_item       (r_in),
        .i_cfg        (r_cfg),
        .o_has_result (has_result),
        .o_result     (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= fire && has_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && has_result) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // an empty beat always closes the string
    a_invalid_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.code_valid |-> o_out.end_of_string && o_out.lcd_code == 8'd0)
        else $error("empty beat without end_of_string or with nonzero code");

    // a sent character is always counted
    a_sent_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.code_valid |-> o_out.chars_sent != 8'd0)
        else $error("character beat with zero count");

    // output register only loads from a decoded byte
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_in_valid))
        else $error("output beat without a byte in the input register");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives byte strings into the UTF-8 Cyrillic to LCD code mapper under both
// charsets and a range of character limits, and checks every output beat
// against an in-bench model of the string decoder.
// ----------------------------------------------------------------------------
module testbench;
    import u8c_pkg::*;

    localparam logic [7:0] GLYPH_I      = 8'h49;
    localparam logic [7:0] GLYPH_YI_ROM = 8'hEA;
    localparam int unsigned LONG_HOLD_CYCLES = 300;
    localparam int unsigned LONG_HOLD_AT     = 600;
    localparam int unsigned SETTLE_CYCLES    = 8;

    // U+0410..U+042F in the display ROM Cyrillic page
    localparam logic [7:0] ROM_GLYPHS [32] = '{
        8'h41, 8'hA0, 8'h42, 8'hA1, 8'hE0, 8'h45, 8'hA3, 8'hA4,
        8'hA5, 8'hA5, 8'h4B, 8'hA6, 8'h4D, 8'h48, 8'h4F, 8'hA7,
        8'h50, 8'h43, 8'h54, 8'hA8, 8'hA9, 8'h58, 8'hAA, 8'hAB,
        8'hAC, 8'hAD, 8'hAE, 8'hAF, 8'hB0, 8'hB1, 8'hB2, 8'hB3
    };

    // same letters as Latin lookalikes, CGRAM glyphs 0..7 for the rest
    localparam logic [7:0] LAT_GLYPHS [32] = '{
        8'h41, 8'h00, 8'h42, 8'h01, 8'h02, 8'h45, 8'h03, 8'h33,
        8'h04, 8'h04, 8'h4B, 8'h05, 8'h4D, 8'h48, 8'h4F, 8'hF7,
        8'h50, 8'h43, 8'h54, 8'h59, 8'h06, 8'h58, 8'hF9, 8'h34,
        8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h62, 8'h3F, 8'h07, 8'h3F
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    t_in_item   in_beat = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    t_out_item  out_beat;
    logic       cfg_we = 1'b0;
    logic       cfg_idx = CFG_CHARSET_MODE;
    logic [7:0] cfg_data = '0;

    t_in_item    pending_bytes [$];
    t_out_item   expected_codes [$];
    int unsigned mismatches = 0;
    int unsigned codes_checked = 0;
    int unsigned in_gap = 0;
    int unsigned out_gap = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    bit          in_burst = 1'b0;
    bit          out_burst = 1'b0;
    bit          sos_pending = 1'b0;

    // model state and its copy of the registers
    logic [1:0] str_lead = LEAD_NONE;
    logic [7:0] str_count = '0;
    logic       str_done = 1'b0;
    logic       cfg_rom = 1'b0;
    logic [7:0] cfg_limit = CHAR_LIMIT_RST;

    utf8_cyrillic_to_lcd_charmap dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_beat),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // offset is the code point minus U+0400
    function automatic logic [7:0] cyr_glyph(input logic [6:0] offset, input logic rom);
        logic [6:0] o;
        logic [6:0] d;
        logic [4:0] slot;
        o = offset;
        if (o >= 7'h30 && o <= 7'h4F) begin
            o = o - 7'h20;          // lowercase folds onto uppercase
        end else if (o == 7'h56 || o == 7'h57) begin
            o = o - 7'h50;          // small i / yi
        end
        d = o - 7'h10;
        slot = d[4:0];
        if (o >= 7'h10 && o <= 7'h2F) begin
            return rom ? ROM_GLYPHS[slot] : LAT_GLYPHS[slot];
        end
        if (o == 7'h06) begin
            return GLYPH_I;
        end
        if (o == 7'h07) begin
            return rom ? GLYPH_YI_ROM : GLYPH_I;
        end
        return CODE_UNKNOWN;
    endfunction

    // advances the string state by one byte; returns 1 when a beat is due
    function automatic bit predict_lcd_code(input t_in_item it, output t_out_item res);
        logic [7:0] b;
        logic [1:0] lead;
        b = it.in_byte;
        res = '0;
        if (it.start_of_string) begin
            str_count = '0;
            str_lead  = LEAD_NONE;
            str_done  = 1'b0;
        end
        if (str_done) begin
            return 1'b0;
        end
        if (str_count >= cfg_limit) begin
            str_lead = LEAD_NONE;
            str_done = 1'b1;
            res.end_of_string = 1'b1;
            res.chars_sent = str_count;
            return 1'b1;
        end
        lead = str_lead;
        if (b == BYTE_NUL) begin
            str_lead = LEAD_NONE;
            str_done = 1'b1;
            res.end_of_string = 1'b1;
            if (lead != LEAD_NONE) begin
                // dangling lead goes out raw
                str_count = str_count + 8'd1;
                res.code_valid = 1'b1;
                res.lcd_code = (lead == LEAD_D0) ? BYTE_LEAD_D0 : BYTE_LEAD_D1;
            end
            res.chars_sent = str_count;
            return 1'b1;
        end
        if (lead != LEAD_NONE) begin
            str_lead = LEAD_NONE;
            b = cyr_glyph({lead == LEAD_D1, b[5:0]}, cfg_rom);
        end else if (b == BYTE_LEAD_D0 || b == BYTE_LEAD_D1) begin
            str_lead = (b == BYTE_LEAD_D0) ? LEAD_D0 : LEAD_D1;
            return 1'b0;
        end else if (it.upper_latin && b >= ASCII_LOW_A && b <= ASCII_LOW_Z) begin
            b = b - CASE_DELTA;
        end
        str_count = str_count + 8'd1;
        res.code_valid = 1'b1;
        res.lcd_code = b;
        res.end_of_string = (str_count >= cfg_limit);
        res.chars_sent = str_count;
        if (res.end_of_string) begin
            str_done = 1'b1;
        end
        return 1'b1;
    endfunction

    // mostly back to back, some short gaps, a few long ones
    function automatic int unsigned pick_gap(input bit burst);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (burst || r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_ready) begin
            if (in_gap > 0) begin
                in_gap   <= in_gap - 1;
                in_valid <= 1'b0;
            end else if (pending_bytes.size() > 0) begin
                in_beat  <= pending_bytes.pop_front();
                in_valid <= 1'b1;
                in_gap   <= pick_gap(in_burst);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver side, with one long hold-off to back the block up
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else if (!hold_done && codes_checked >= LONG_HOLD_AT) begin
            hold_left <= LONG_HOLD_CYCLES;
            hold_done <= 1'b1;
            out_ready <= 1'b0;
        end else if (out_gap > 0) begin
            out_gap   <= out_gap - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
            out_gap   <= pick_gap(out_burst);
        end
    end

    always @(posedge clk) begin : scoreboard
        t_out_item want;
        t_out_item next_code;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (expected_codes.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected beat, expected none,", $time,
                             " got code %h valid %b end %b sent %0d",
                             out_beat.lcd_code, out_beat.code_valid,
                             out_beat.end_of_string, out_beat.chars_sent);
                end else begin
                    want = expected_codes.pop_front();
                    codes_checked <= codes_checked + 1;
                    if (out_beat.lcd_code !== want.lcd_code
                            || out_beat.code_valid !== want.code_valid
                            || out_beat.end_of_string !== want.end_of_string
                            || out_beat.chars_sent !== want.chars_sent) begin
                        mismatches++;
                        $display("%0t: expected code %h valid %b end %b sent %0d,",
                                 $time, want.lcd_code, want.code_valid,
                                 want.end_of_string, want.chars_sent,
                                 " got code %h valid %b end %b sent %0d",
                                 out_beat.lcd_code, out_beat.code_valid,
                                 out_beat.end_of_string, out_beat.chars_sent);
                    end
                end
            end
            if (in_valid && in_ready) begin
                if (predict_lcd_code(in_beat, next_code)) begin
                    expected_codes.push_back(next_code);
                end
            end
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic sos, input logic up);
        t_in_item it;
        it.in_byte = b;
        it.start_of_string = sos;
        it.upper_latin = up;
        pending_bytes.push_back(it);
    endtask

    // random-content byte; first of a string carries the start flag, rarely a stray one
    task automatic push_rand(input logic [7:0] b);
        push_byte(b, sos_pending || ($urandom_range(0, 99) == 0), 1'($urandom_range(0, 1)));
        sos_pending = 1'b0;
    endtask

    task automatic add_string(input int unsigned len);
        int unsigned k;
        int unsigned kind;
        logic [7:0] b;
        sos_pending = 1'b1;
        for (k = 0; k < len; k++) begin
            kind = $urandom_range(0, 9);
            if (kind < 4) begin
                push_rand($urandom_range(0, 1) ? BYTE_LEAD_D1 : BYTE_LEAD_D0);
                b = 8'h80 | 8'($urandom_range(0, 63));
                push_rand(b);
            end else if (kind < 8) begin
                b = 8'($urandom_range(8'h20, 8'h7E));
                push_rand(b);
            end else if (kind == 8) begin
                // lead followed by anything nonzero
                push_rand($urandom_range(0, 1) ? BYTE_LEAD_D1 : BYTE_LEAD_D0);
                b = 8'($urandom_range(1, 255));
                push_rand(b);
            end else begin
                b = 8'($urandom_range(1, 255));
                push_rand(b);
            end
        end
        kind = $urandom_range(0, 9);
        if (kind < 7) begin
            push_rand(BYTE_NUL);
        end else if (kind == 7) begin
            push_rand($urandom_range(0, 1) ? BYTE_LEAD_D1 : BYTE_LEAD_D0);
            push_rand(BYTE_NUL);
        end else if (kind == 9) begin
            // trailing junk after the terminator
            push_rand(BYTE_NUL);
            b = 8'($urandom_range(0, 255));
            push_rand(b);
            b = 8'($urandom_range(0, 255));
            push_rand(b);
        end
    endtask

    task automatic add_strings(input int unsigned n_bytes);
        int unsigned start_size;
        start_size = pending_bytes.size();
        while (pending_bytes.size() - start_size < n_bytes) begin
            add_string(($urandom_range(0, 99) < 85) ? $urandom_range(0, 12)
                                                   : $urandom_range(13, 40));
        end
    endtask

    // waits for everything to drain, then for the pipeline to go quiet
    task automatic settle();
        do begin
            @(negedge clk);
        end while (pending_bytes.size() != 0 || in_valid || expected_codes.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] val);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_CHARSET_MODE) begin
            cfg_rom = val[0];
        end else begin
            cfg_limit = val;
        end
    endtask

    task automatic configure(input logic rom, input logic [7:0] limit);
        write_reg(CFG_CHARSET_MODE, {7'd0, rom});
        write_reg(CFG_CHAR_LIMIT, limit);
        @(negedge clk);
        in_burst  = ($urandom_range(0, 3) == 0);
        out_burst = ($urandom_range(0, 3) == 0);
    endtask

    initial begin : stimulus
        int unsigned ph;
        int unsigned k;
        logic [7:0] b;
        rst_n <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ROM charset: case folding, Ukrainian letters, unknown, raw lead at end
        configure(1'b1, CHAR_LIMIT_RST);
        push_byte(ASCII_LOW_A, 1'b1, 1'b1);
        push_byte(ASCII_LOW_Z, 1'b0, 1'b0);
        push_byte(BYTE_LEAD_D0, 1'b0, 1'b0);
        push_byte(8'h90, 1'b0, 1'b0);
        push_byte(BYTE_LEAD_D1, 1'b0, 1'b0);
        push_byte(8'h8F, 1'b0, 1'b0);
        push_byte(BYTE_LEAD_D0, 1'b0, 1'b1);
        push_byte(8'h86, 1'b0, 1'b0);
        push_byte(BYTE_LEAD_D1, 1'b0, 1'b0);
        push_byte(8'h97, 1'b0, 1'b0);
        push_byte(BYTE_LEAD_D0, 1'b0, 1'b0);
        push_byte(8'h80, 1'b0, 1'b0);
        push_byte(8'hFF, 1'b0, 1'b1);
        push_byte(BYTE_LEAD_D1, 1'b0, 1'b0);
        push_byte(BYTE_NUL, 1'b0, 1'b0);
        push_byte(ASCII_LOW_A, 1'b0, 1'b0);     // after the end: dropped
        push_byte(BYTE_NUL, 1'b1, 1'b0);        // empty string
        push_byte(BYTE_LEAD_D0, 1'b1, 1'b0);
        push_byte(8'h41, 1'b0, 1'b0);           // ASCII completing a lead
        push_byte(BYTE_NUL, 1'b0, 1'b0);
        settle();

        // Latin lookalikes, string left open with a lead held
        configure(1'b0, CHAR_LIMIT_RST);
        push_byte(BYTE_LEAD_D0, 1'b1, 1'b0);
        push_byte(8'hA4, 1'b0, 1'b0);
        push_byte(BYTE_LEAD_D1, 1'b0, 1'b0);
        push_byte(8'h8C, 1'b0, 1'b0);
        push_byte(ASCII_LOW_Z, 1'b0, 1'b1);
        push_byte(BYTE_LEAD_D0, 1'b0, 1'b0);
        settle();

        // limit dropped below the running count, then hit by a send
        configure(1'b0, 8'd2);
        push_byte(ASCII_LOW_A, 1'b0, 1'b0);
        push_byte(ASCII_LOW_Z, 1'b0, 1'b0);
        push_byte(ASCII_LOW_A, 1'b1, 1'b0);
        push_byte(ASCII_LOW_Z, 1'b0, 1'b1);
        settle();

        // zero limit: every string ends on its first byte
        configure(1'b1, 8'd0);
        push_byte(ASCII_LOW_A, 1'b1, 1'b0);
        push_byte(BYTE_LEAD_D0, 1'b1, 1'b1);
        settle();

        // full limit with one string long enough to reach it
        configure(1'b0, 8'd255);
        push_byte(8'h21, 1'b1, 1'b0);
        for (k = 0; k < 270; k++) begin
            b = $urandom_range(0, 1) ? 8'h80 | 8'($urandom_range(0, 63))
                                     : 8'($urandom_range(8'h20, 8'h7E));
            if (b[7]) begin
                push_byte($urandom_range(0, 1) ? BYTE_LEAD_D1 : BYTE_LEAD_D0, 1'b0, 1'b0);
            end
            push_byte(b, 1'b0, 1'($urandom_range(0, 1)));
        end
        add_strings(150);
        settle();

        for (ph = 0; ph < 6; ph++) begin
            case (ph)
                0: configure(1'b1, CHAR_LIMIT_RST);
                1: configure(1'b0, 8'd1);
                2: configure(1'b1, 8'($urandom_range(2, 12)));
                3: configure(1'b0, 8'($urandom_range(13, 254)));
                4: configure(1'b1, 8'd255);
                default: configure(1'b0, 8'($urandom_range(2, 8)));
            endcase
            add_strings(175);
            settle();
        end

        if (mismatches == 0 && expected_codes.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/u8c_pkg.sv
rtl/u8c_map.sv
rtl/u8c_step.sv
rtl/utf8_cyrillic_to_lcd_charmap.sv
tb/testbench.sv
